[hdl/three_shunt_current_reconstruct_defines.svh]
// Assertion macros used by the current reconstruction RTL
`ifndef THREE_SHUNT_CURRENT_RECONSTRUCT_DEFINES_SVH
`define THREE_SHUNT_CURRENT_RECONSTRUCT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// plain property, sampled on clk_i, off while in reset
`define TSCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication, sampled on clk_i, off while in reset
`define TSCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define TSCR_ASSERT(lbl, prop, msg)
`define TSCR_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

[hdl/tscr_pkg.sv]
// Types, constants and saturation helpers for the current reconstruction block
package tscr_pkg;

  localparam int unsigned NUM_PHASES = 3;

  typedef logic signed [15:0] cur_t;   // scaled phase current
  typedef logic signed [16:0] corr_t;  // recentred minus offset
  typedef logic signed [17:0] wide_t;  // headroom before saturation

  typedef enum logic [1:0] {
    PAIR_UV   = 2'd0,
    PAIR_UW   = 2'd1,
    PAIR_VW   = 2'd2,
    PAIR_NONE = 2'd3
  } pair_e;

  typedef enum logic [7:0] {
    CFG_OFFSET_U = 8'd0,
    CFG_OFFSET_V = 8'd1,
    CFG_OFFSET_W = 8'd2,
    CFG_GAIN     = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic  valid;
    logic  cal;
    pair_e pair;
  } ctl_t;

  localparam logic [15:0] GAIN_RESET   = 16'd32768;
  localparam logic [16:0] MIDSCALE     = 17'd32768;
  localparam int unsigned GAIN_SHIFT   = 15;
  localparam wide_t       SAT_HI       = 18'sd32767;
  localparam wide_t       SAT_LO       = -18'sd32767;
  localparam cur_t        CUR_NEG_FULL = 16'sh8000;

  function automatic cur_t sat_wide(input wide_t x);
    cur_t r;
    if (x > SAT_HI) begin
      r = cur_t'(SAT_HI);
    end else if (x < SAT_LO) begin
      r = cur_t'(SAT_LO);
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // saturated negative of the sum of two currents
  function automatic cur_t neg_sum(input cur_t a, input cur_t b);
    wide_t s;
    s = -wide_t'(a) - wide_t'(b);
    return sat_wide(s);
  endfunction

endpackage

[hdl/tscr_if.sv]
// Channel interfaces: sample input, current output and register write
interface tscr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_u;
  logic [15:0] raw_v;
  logic [15:0] raw_w;
  logic [1:0]  sensor_pair;
  logic        calibrate;

  modport source (output valid, raw_u, raw_v, raw_w, sensor_pair, calibrate, input ready);
  modport sink   (input valid, raw_u, raw_v, raw_w, sensor_pair, calibrate, output ready);
endinterface

interface tscr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cur_u;
  logic signed [15:0] cur_v;
  logic signed [15:0] cur_w;
  logic signed [16:0] corrected_u;
  logic signed [16:0] corrected_v;
  logic signed [16:0] corrected_w;

  modport source (output valid, cur_u, cur_v, cur_w, corrected_u, corrected_v, corrected_w,
                  input ready);
  modport sink   (input valid, cur_u, cur_v, cur_w, corrected_u, corrected_v, corrected_w,
                  output ready);
endinterface

interface tscr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tscr_lane.sv]
// One phase lane: recentre, offset, saturate, Q15 gain multiply
module tscr_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [15:0]    raw_i,
  input  logic [15:0]    offset_i,
  input  logic [15:0]    gain_i,
  output tscr_pkg::cur_t  scaled_o,
  output tscr_pkg::corr_t corr_o
);
  import tscr_pkg::*;

  wide_t              corr_full;
  corr_t              corr_d, corr_q, corr2_q;
  logic signed [32:0] prod_d, prod_q;

  // range is -65535..65535, so 17 bits hold it
  assign corr_full = $signed({2'b00, raw_i}) - $signed({1'b0, MIDSCALE})
                     - $signed({{2{offset_i[15]}}, offset_i});
  assign corr_d    = corr_full[16:0];

  assign prod_d = 33'(sat_wide(wide_t'(corr_q))) * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      corr_q  <= corr_d;
      prod_q  <= prod_d;
      corr2_q <= corr_q;
    end
  end

  // arithmetic shift rounds towards minus infinity
  assign scaled_o = sat_wide(prod_q[32:GAIN_SHIFT]);
  assign corr_o   = corr2_q;

endmodule

[hdl/tscr_merge.sv]
// Merge stage: third-phase reconstruction, mode select and output register
`include "three_shunt_current_reconstruct_defines.svh"

module tscr_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  tscr_pkg::ctl_t  ctl_i,
  input  tscr_pkg::cur_t  scaled_i [3],
  input  tscr_pkg::corr_t corr_i [3],
  output logic            valid_o,
  output tscr_pkg::cur_t  cur_o [3],
  output tscr_pkg::corr_t cor_o [3]
);
  import tscr_pkg::*;

  ctl_t  ctl_q;
  cur_t  cur_d [NUM_PHASES];
  cur_t  cur_q [NUM_PHASES];
  corr_t cor_d [NUM_PHASES];
  corr_t cor_q [NUM_PHASES];

  always_comb begin
    for (int i = 0; i < NUM_PHASES; i++) begin
      cur_d[i] = '0;
      cor_d[i] = '0;
    end
    if (ctl_i.cal) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        cur_d[i] = scaled_i[i];
        cor_d[i] = corr_i[i];
      end
    end else begin
      unique case (ctl_i.pair)
        PAIR_UV: begin
          cur_d[0] = scaled_i[0];
          cur_d[1] = scaled_i[1];
          cur_d[2] = neg_sum(scaled_i[0], scaled_i[1]);
        end
        PAIR_UW: begin
          cur_d[0] = scaled_i[0];
          cur_d[2] = scaled_i[2];
          cur_d[1] = neg_sum(scaled_i[0], scaled_i[2]);
        end
        PAIR_VW: begin
          cur_d[1] = scaled_i[1];
          cur_d[2] = scaled_i[2];
          cur_d[0] = neg_sum(scaled_i[1], scaled_i[2]);
        end
        default: ;  // unused selector: all zero
      endcase
      for (int i = 0; i < NUM_PHASES; i++) begin
        cor_d[i] = corr_t'(cur_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        cur_q[i] <= cur_d[i];
        cor_q[i] <= cor_d[i];
      end
    end
  end

  assign valid_o = ctl_q.valid;
  always_comb begin
    for (int i = 0; i < NUM_PHASES; i++) begin
      cur_o[i] = cur_q[i];
      cor_o[i] = cor_q[i];
    end
  end

  `TSCR_ASSERT_IMP(a_cur_sat, ctl_q.valid,
    cur_q[0] != CUR_NEG_FULL && cur_q[1] != CUR_NEG_FULL && cur_q[2] != CUR_NEG_FULL,
    "current left saturation range")
  `TSCR_ASSERT_IMP(a_cor_repeat, ctl_q.valid && !ctl_q.cal,
    cor_q[0] == corr_t'(cur_q[0]) && cor_q[1] == corr_t'(cur_q[1])
    && cor_q[2] == corr_t'(cur_q[2]),
    "corrected output differs from current in normal mode")
  `TSCR_ASSERT_IMP(a_unused_pair, ctl_q.valid && !ctl_q.cal && ctl_q.pair == PAIR_NONE,
    cur_q[0] == '0 && cur_q[1] == '0 && cur_q[2] == '0,
    "unused pair selector gave non-zero current")

endmodule

[hdl/three_shunt_current_reconstruct.sv]
// Top level of the three-shunt phase current reconstruction block
//
// Usage:
//   in_i  : one transaction carries the three raw ADC samples (midscale is zero
//           current), the sensed-pair selector and the calibrate flag.
//   out_o : one transaction per input; scaled currents and offset-corrected values.
//   cfg_i : register writes, index 0..2 offsets U/V/W, 3 gain (Q15). Other indexes
//           are accepted and ignored. Write only while the block is empty.
// Timing:
//   Three register stages (lane offset stage, lane multiplier stage, merge
//   output register). A result is presented once its input transaction has
//   passed all three, and a new transaction is taken every cycle unless out_o stalls.
//   Rate is one item per cycle unless out_o stalls; one 16x17 multiplier per lane.
// Reset:
//   Offsets clear to zero, gain to unity (32768), pipeline empty. No clearing
//   pass; the block takes input from the first cycle after reset.
// Back-pressure:
//   The whole pipe holds while a result waits and out_o.ready is low; in_i.ready
//   drops with it, so nothing is lost or repeated. Bubbles are carried through.
module three_shunt_current_reconstruct (
  input  logic       clk_i,
  input  logic       rst_ni,
  tscr_in_if.sink    in_i,
  tscr_out_if.source out_o,
  tscr_cfg_if.sink   cfg_i
);
  import tscr_pkg::*;

  // configuration registers
  logic [15:0] off_q [NUM_PHASES];
  logic [15:0] gain_q;

  // pipeline advance: the output register is free or being drained
  logic adv;

  ctl_t  ctl1_q, ctl2_q, ctl1_d;
  logic [15:0] raw [NUM_PHASES];
  cur_t  scaled [NUM_PHASES];
  corr_t corr [NUM_PHASES];
  cur_t  cur [NUM_PHASES];
  corr_t cor [NUM_PHASES];
  logic  out_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        off_q[i] <= '0;
      end
      gain_q <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OFFSET_U: off_q[0] <= cfg_i.data;
        CFG_OFFSET_V: off_q[1] <= cfg_i.data;
        CFG_OFFSET_W: off_q[2] <= cfg_i.data;
        CFG_GAIN:     gain_q   <= cfg_i.data;
        default: ;    // beyond the register list
      endcase
    end
  end

  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;

  assign raw[0] = in_i.raw_u;
  assign raw[1] = in_i.raw_v;
  assign raw[2] = in_i.raw_w;

  assign ctl1_d = '{valid: in_i.valid, cal: in_i.calibrate, pair: pair_e'(in_i.sensor_pair)};

  // mode bits travel alongside the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
    end
  end

  // one lane per phase, all three enabled by the same advance signal
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_lane
    tscr_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .raw_i    (raw[p]),
      .offset_i (off_q[p]),
      .gain_i   (gain_q),
      .scaled_o (scaled[p]),
      .corr_o   (corr[p])
    );
  end

  tscr_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .ctl_i    (ctl2_q),
    .scaled_i (scaled),
    .corr_i   (corr),
    .valid_o  (out_valid),
    .cur_o    (cur),
    .cor_o    (cor)
  );

  assign out_o.valid       = out_valid;
  assign out_o.cur_u       = cur[0];
  assign out_o.cur_v       = cur[1];
  assign out_o.cur_w       = cur[2];
  assign out_o.corrected_u = cor[0];
  assign out_o.corrected_v = cor[1];
  assign out_o.corrected_w = cor[2];

endmodule
